@@ hw/rtl/wpp_pkg.sv @@
`default_nettype none

package wpp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PLANE_ZOOM     = 3'd0;
  localparam cfg_index_t REG_HEIGHT_ZOOM    = 3'd1;
  localparam cfg_index_t REG_CENTER_OFFSETS = 3'd2;
  localparam cfg_index_t REG_SCREEN_OFFSETS = 3'd3;
  localparam cfg_index_t REG_ISO_TRIG       = 3'd4;
  localparam cfg_index_t REG_TILT_X_TRIG    = 3'd5;
  localparam cfg_index_t REG_TILT_Y_TRIG    = 3'd6;
  localparam cfg_index_t REG_TILT_Z_TRIG    = 3'd7;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } trig_t;

  localparam logic [15:0] ZOOM_RESET = 16'd256;
  localparam trig_t       TRIG_RESET = 32'h4000_0000;

  localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

@@ hw/rtl/wpp_if.sv @@
`default_nettype none

interface wpp_point_if #(
  parameter int GRID_BITS = 10
) ();
  logic                 valid;
  logic                 ready;
  logic [GRID_BITS-1:0] grid_col;
  logic [GRID_BITS-1:0] grid_row;
  logic signed [15:0]   elevation;

  modport source(output valid, output grid_col, output grid_row, output elevation,
                 input ready);
  modport sink(input valid, input grid_col, input grid_row, input elevation,
               output ready);
endinterface

interface wpp_result_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_z;

  modport source(output valid, output screen_x, output screen_y, output depth_z,
                 input ready);
  modport sink(input valid, input screen_x, input screen_y, input depth_z,
               output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wireframe_point_projector_top.sv @@
`default_nettype none

// Projects one map point (column, row, elevation) per request to a screen
// position and depth in signed Q24.8, saturated to 32 bits. The block is a
// twelve-stage pipeline: it takes one request every cycle unless
// backpressure from the result side reaches the first stage. The stages
// are five for the zoom, centering, truncation and isometric step, the
// product and sum stages of each of the three rotations, and one stage
// for the screen offsets and saturation. Backpressure moves back stage by
// stage, so empty stages still fill while a result waits. Registers are
// written through wr_en, wr_index and wr_data; the user must write them
// only while no request is in flight, which the block does not enforce;
// cosine and sine pairs are Q1.14, cosine in the upper half.
module wireframe_point_projector_top #(
  parameter int GRID_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  wpp_point_if.sink                        point,
  wpp_result_if.source                     result,
  input  logic                             wr_en,
  input  logic [wpp_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [wpp_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int NS  = 12;
  localparam int PW  = GRID_BITS + 16;
  localparam int XW  = ((PW + 1 > 24) ? PW + 1 : 24) + 1;
  localparam int IW  = XW - 8;
  localparam int DW  = IW + 1;
  localparam int MW  = DW + 16;
  localparam int PXW = DW + 10;
  localparam int PYW = ((PXW > 33) ? PXW : 33) + 1;
  localparam int O1  = ((PYW > 32) ? PYW : 32) + 3;
  localparam int O2  = ((PXW > O1) ? PXW : O1) + 3;
  localparam int O3  = ((O2 > O1) ? O2 : O1) + 3;
  localparam int FW  = O3 + 1;

  logic [15:0]        plane_zoom;
  logic [15:0]        height_zoom;
  logic signed [23:0] x_center;
  logic signed [23:0] y_center;
  logic signed [15:0] x_screen;
  logic signed [15:0] y_screen;
  wpp_pkg::trig_t     iso;
  wpp_pkg::trig_t     tilt_x;
  wpp_pkg::trig_t     tilt_y;
  wpp_pkg::trig_t     tilt_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_zoom  <= wpp_pkg::ZOOM_RESET;
      height_zoom <= wpp_pkg::ZOOM_RESET;
      x_center    <= '0;
      y_center    <= '0;
      x_screen    <= '0;
      y_screen    <= '0;
      iso         <= wpp_pkg::TRIG_RESET;
      tilt_x      <= wpp_pkg::TRIG_RESET;
      tilt_y      <= wpp_pkg::TRIG_RESET;
      tilt_z      <= wpp_pkg::TRIG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        wpp_pkg::REG_PLANE_ZOOM: begin
          plane_zoom <= wr_data[15:0];
        end
        wpp_pkg::REG_HEIGHT_ZOOM: begin
          height_zoom <= wr_data[15:0];
        end
        wpp_pkg::REG_CENTER_OFFSETS: begin
          x_center <= wr_data[47:24];
          y_center <= wr_data[23:0];
        end
        wpp_pkg::REG_SCREEN_OFFSETS: begin
          x_screen <= wr_data[31:16];
          y_screen <= wr_data[15:0];
        end
        wpp_pkg::REG_ISO_TRIG: begin
          iso <= wpp_pkg::trig_t'(wr_data[31:0]);
        end
        wpp_pkg::REG_TILT_X_TRIG: begin
          tilt_x <= wpp_pkg::trig_t'(wr_data[31:0]);
        end
        wpp_pkg::REG_TILT_Y_TRIG: begin
          tilt_y <= wpp_pkg::trig_t'(wr_data[31:0]);
        end
        wpp_pkg::REG_TILT_Z_TRIG: begin
          tilt_z <= wpp_pkg::trig_t'(wr_data[31:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic [NS:1] v;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !v[NS] || result.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= point.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign point.ready  = adv[1] && !rst;
  assign result.valid = v[NS];

  // zoom
  logic [GRID_BITS-1:0] col;
  logic [GRID_BITS-1:0] row;
  logic signed [16:0]   hz;
  logic [PW-1:0]        s1_pc;
  logic [PW-1:0]        s1_pr;
  logic signed [31:0]   s1_zf;

  assign col = GRID_BITS'(point.grid_col);
  assign row = GRID_BITS'(point.grid_row);
  assign hz  = $signed({1'b0, height_zoom});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pc <= PW'(col) * PW'(plane_zoom);
      s1_pr <= PW'(row) * PW'(plane_zoom);
      s1_zf <= 32'(point.elevation) * 32'(hz);
    end
  end

  // centering
  logic signed [XW-1:0] pc_ext;
  logic signed [XW-1:0] pr_ext;
  logic signed [XW-1:0] s2_x;
  logic signed [XW-1:0] s2_y;
  logic signed [31:0]   s2_zf;

  assign pc_ext = XW'(s1_pc);
  assign pr_ext = XW'(s1_pr);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_x  <= pc_ext - XW'(x_center);
      s2_y  <= pr_ext - XW'(y_center);
      s2_zf <= s1_zf;
    end
  end

  // truncate toward zero, iso sum and difference
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [31:0]   zs;
  logic signed [IW-1:0] xi;
  logic signed [IW-1:0] yi;
  logic signed [23:0]   zi;
  logic signed [DW-1:0] s3_d;
  logic signed [DW-1:0] s3_s;
  logic signed [23:0]   s3_zi;
  logic signed [31:0]   s3_zf;

  always_comb begin
    xs = s2_x >>> 8;
    ys = s2_y >>> 8;
    zs = s2_zf >>> 8;
    xi = IW'(xs) + IW'(s2_x[XW-1] && (s2_x[7:0] != 8'd0));
    yi = IW'(ys) + IW'(s2_y[XW-1] && (s2_y[7:0] != 8'd0));
    zi = 24'(zs) + 24'(s2_zf[31] && (s2_zf[7:0] != 8'd0));
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d  <= DW'(xi) - DW'(yi);
      s3_s  <= DW'(xi) + DW'(yi);
      s3_zi <= zi;
      s3_zf <= s2_zf;
    end
  end

  // iso products
  logic signed [MW-1:0] s4_md;
  logic signed [MW-1:0] s4_ms;
  logic signed [23:0]   s4_zi;
  logic signed [31:0]   s4_zf;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_md <= MW'(s3_d) * MW'($signed(iso.cos_v));
      s4_ms <= MW'(s3_s) * MW'($signed(iso.sin_v));
      s4_zi <= s3_zi;
      s4_zf <= s3_zf;
    end
  end

  // iso rescale
  logic signed [MW-1:0]  md_sh;
  logic signed [MW-1:0]  ms_sh;
  logic signed [PYW-1:0] zw;
  logic signed [PXW-1:0] s5_px;
  logic signed [PYW-1:0] s5_py;
  logic signed [31:0]    s5_pz;

  always_comb begin
    md_sh = s4_md >>> 6;
    ms_sh = s4_ms >>> 6;
    zw    = PYW'(s4_zi);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_px <= md_sh[PXW-1:0];
      s5_py <= PYW'(ms_sh) - (zw <<< 8);
      s5_pz <= s4_zf;
    end
  end

  // rotation about x
  logic signed [O1-1:0]  r1_py;
  logic signed [O1-1:0]  r1_pz;
  logic signed [PXW-1:0] s6_px;
  logic signed [PXW-1:0] s7_px;

  wpp_rotate #(
    .AW(PYW),
    .BW(32)
  ) u_rot_x (
    .clk   (clk),
    .adv   (adv[7:6]),
    .trig  (tilt_x),
    .a     (s5_py),
    .b     (s5_pz),
    .a_rot (r1_py),
    .b_rot (r1_pz)
  );

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_px <= s5_px;
    end
    if (adv[7]) begin
      s7_px <= s6_px;
    end
  end

  // rotation about y
  logic signed [O2-1:0] r2_px;
  logic signed [O2-1:0] r2_pz;
  logic signed [O1-1:0] s8_py;
  logic signed [O1-1:0] s9_py;

  wpp_rotate #(
    .AW(PXW),
    .BW(O1)
  ) u_rot_y (
    .clk   (clk),
    .adv   (adv[9:8]),
    .trig  (tilt_y),
    .a     (s7_px),
    .b     (r1_pz),
    .a_rot (r2_px),
    .b_rot (r2_pz)
  );

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_py <= r1_py;
    end
    if (adv[9]) begin
      s9_py <= s8_py;
    end
  end

  // rotation about z
  logic signed [O3-1:0] r3_px;
  logic signed [O3-1:0] r3_py;
  logic signed [O2-1:0] s10_pz;
  logic signed [O2-1:0] s11_pz;

  wpp_rotate #(
    .AW(O2),
    .BW(O1)
  ) u_rot_z (
    .clk   (clk),
    .adv   (adv[11:10]),
    .trig  (tilt_z),
    .a     (r2_px),
    .b     (s9_py),
    .a_rot (r3_px),
    .b_rot (r3_py)
  );

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s10_pz <= r2_pz;
    end
    if (adv[11]) begin
      s11_pz <= s10_pz;
    end
  end

  // screen offsets and saturation
  function automatic logic signed [31:0] sat32(input logic signed [FW-1:0] val);
    logic signed [31:0] res;
    if (val > FW'(wpp_pkg::OUT_MAX)) begin
      res = wpp_pkg::OUT_MAX;
    end else if (val < FW'(wpp_pkg::OUT_MIN)) begin
      res = wpp_pkg::OUT_MIN;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;
  logic signed [FW-1:0] fz;
  logic signed [FW-1:0] ox_w;
  logic signed [FW-1:0] oy_w;
  logic signed [31:0]   out_x;
  logic signed [31:0]   out_y;
  logic signed [31:0]   out_z;

  always_comb begin
    ox_w = FW'(x_screen);
    oy_w = FW'(y_screen);
    fx   = FW'(r3_px) + (ox_w <<< 8);
    fy   = FW'(r3_py) + (oy_w <<< 8);
    fz   = FW'(s11_pz);
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      out_x <= sat32(fx);
      out_y <= sat32(fy);
      out_z <= sat32(fz);
    end
  end

  assign result.screen_x = out_x;
  assign result.screen_y = out_y;
  assign result.depth_z  = out_z;

endmodule

`default_nettype wire

@@ hw/rtl/wpp_rotate.sv @@
`default_nettype none

module wpp_rotate #(
  parameter int AW = 34,
  parameter int BW = 32,
  parameter int OW = ((AW > BW) ? AW : BW) + 3
) (
  input  logic                 clk,
  input  logic [1:0]           adv,
  input  wpp_pkg::trig_t       trig,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] a_rot,
  output logic signed [OW-1:0] b_rot
);

  localparam int PAW = AW + 16;
  localparam int PBW = BW + 16;
  localparam int SW  = OW + 14;

  logic signed [PAW-1:0] ac;
  logic signed [PAW-1:0] as_p;
  logic signed [PBW-1:0] bc;
  logic signed [PBW-1:0] bs;
  logic signed [SW-1:0]  sa;
  logic signed [SW-1:0]  sb;
  logic signed [SW-1:0]  sa_sh;
  logic signed [SW-1:0]  sb_sh;

  // product stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ac   <= PAW'(a) * PAW'($signed(trig.cos_v));
      as_p <= PAW'(a) * PAW'($signed(trig.sin_v));
      bc   <= PBW'(b) * PBW'($signed(trig.cos_v));
      bs   <= PBW'(b) * PBW'($signed(trig.sin_v));
    end
  end

  always_comb begin
    sa    = SW'(ac) + SW'(bs);
    sb    = SW'(bc) - SW'(as_p);
    sa_sh = sa >>> 14;
    sb_sh = sb >>> 14;
  end

  // sum and rescale stage
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      a_rot <= sa_sh[OW-1:0];
      b_rot <= sb_sh[OW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpp_checker.sv @@
`default_nettype none

module wpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [95:0] out_data
);

  localparam int LAT = 12;

  // consecutive cycles with the result side ready and no reset
  logic [3:0] run;

  always_ff @(posedge clk) begin
    if (rst || !out_ready) begin
      run <= '0;
    end else if (run != 4'hF) begin
      run <= run + 4'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("request refused while result side ready");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && in_ready, LAT) && (run >= 4'(LAT)) |-> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind wireframe_point_projector_top wpp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (point.valid),
  .in_ready  (point.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  ({result.screen_x, result.screen_y, result.depth_z})
);

`default_nettype wire
